FILE: sv/stl_pkg.sv
package stl_pkg;

  // Width of the internal row and column counters; results carry the low 16 bits.
  localparam int unsigned POS_WIDTH = 16;
  localparam int unsigned OUT_POS_WIDTH = 16;

  typedef logic [POS_WIDTH-1:0] pos_t;
  localparam pos_t POS_ONE = pos_t'(1);
  localparam pos_t POS_MAX = '1;

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_QUOTE      = 8'h27;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_ID   = 2'd1,
    MODE_NUM  = 2'd2,
    MODE_DOT  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    KIND_END   = 3'd0,
    KIND_IDENT = 3'd1,
    KIND_INT   = 3'd2,
    KIND_FLOAT = 3'd3,
    KIND_PUNCT = 3'd4,
    KIND_ERROR = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_BAD_INT    = 3'd1,
    ERR_BAD_FLOAT  = 3'd2,
    ERR_INT_RANGE  = 3'd3,
    ERR_UNEXPECTED = 3'd4
  } err_e;

  // Pre-decoded source byte, produced by the front and consumed by the scanner.
  typedef struct packed {
    logic [7:0] ch;
    logic [3:0] digit;
    logic       is_zero;
    logic       is_space;
    logic       is_alpha;
    logic       is_digit;
    logic       is_dot;
    logic       is_punct;
    logic       is_idmid;
    logic       is_nl;
  } byte_class_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  punct;
    logic [63:0] value;
    logic [OUT_POS_WIDTH-1:0] first_row;
    logic [OUT_POS_WIDTH-1:0] first_col;
    logic [OUT_POS_WIDTH-1:0] end_row;
    logic [OUT_POS_WIDTH-1:0] end_col;
    err_e        err;
    logic        last;
  } result_t;

  // Write strobes from the scanner into the result queue.
  typedef struct packed {
    logic push0;
    logic push1;
  } rq_push_t;

  function automatic logic [OUT_POS_WIDTH-1:0] pos_field(pos_t p);
    logic [31:0] w;
    w = 32'(p);
    return w[OUT_POS_WIDTH-1:0];
  endfunction

endpackage

FILE: sv/source_token_lexer_core.sv
// A byte accepted by the front is registered in its queue; the scanner takes it when the
// result queue has room for two more results and writes the byte's results there.
// Throughput: one byte per cycle while the result queue has room; a byte that closes a
// token and makes a punctuation, end or error result yields two, drained one per cycle of pop.
// Reset (rst_ni, asynchronous, active low) empties both queues, sets the scanner
// to idle and the position to row 1, column 1.
module source_token_lexer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  source_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  token_kind_o,
  output logic [7:0]  punct_char_o,
  output logic [63:0] int_value_o,
  output logic [15:0] first_row_o,
  output logic [15:0] first_col_o,
  output logic [15:0] end_row_o,
  output logic [15:0] end_col_o,
  output logic [2:0]  error_code_o,
  output logic        last_of_run_o
);
  import stl_pkg::*;

  // Front to scanner: a two-entry queue of pre-decoded bytes, so that the
  // front keeps taking bytes while the scanner waits on the result queue.
  byte_class_t cls;
  logic        cls_valid;
  logic        cls_take;

  // Scanner to result queue: up to two results per transaction.
  rq_push_t    rq_push;
  result_t     res0;
  result_t     res1;
  logic        rq_room;
  result_t     head;

  stl_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .source_byte_i (source_byte_i),
    .full          (full),
    .cls_o         (cls),
    .cls_valid_o   (cls_valid),
    .cls_take_i    (cls_take)
  );

  // The scanner takes a byte only when the result queue can absorb two more
  // results, so no result is ever dropped.
  stl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_i       (cls),
    .cls_valid_i (cls_valid),
    .cls_take_o  (cls_take),
    .room_i      (rq_room),
    .push_o      (rq_push),
    .res0_o      (res0),
    .res1_o      (res1)
  );

  // The result queue is the output register: its head is shown while it is
  // not empty and advances on each pop transaction.
  stl_resq u_resq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (rq_push),
    .res0_i (res0),
    .res1_i (res1),
    .pop    (pop),
    .empty  (empty),
    .room_o (rq_room),
    .head_o (head)
  );

  assign token_kind_o  = head.kind;
  assign punct_char_o  = head.punct;
  assign int_value_o   = head.value;
  assign first_row_o   = head.first_row;
  assign first_col_o   = head.first_col;
  assign end_row_o     = head.end_row;
  assign end_col_o     = head.end_col;
  assign error_code_o  = head.err;
  assign last_of_run_o = head.last;

endmodule

FILE: sv/stl_front.sv
module stl_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  input  logic [7:0]          source_byte_i,
  output logic                full,
  output stl_pkg::byte_class_t cls_o,
  output logic                cls_valid_o,
  input  logic                cls_take_i
);
  import stl_pkg::*;

  byte_class_t fifo_q [2];
  logic        wptr_q, wptr_d;
  logic        rptr_q, rptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        accept;
  logic        take;

  function automatic byte_class_t classify(logic [7:0] b);
    byte_class_t c;
    c.ch       = b;
    c.digit    = b[3:0];
    c.is_zero  = (b == 8'h00);
    c.is_space = (b == 8'h20) || (b inside {[8'h09:8'h0D]});
    c.is_alpha = (b inside {[8'h61:8'h7A]}) || (b inside {[8'h41:8'h5A]});
    c.is_digit = (b inside {[8'h30:8'h39]});
    c.is_dot   = (b == CH_DOT);
    c.is_punct = (b inside {CH_DOT, 8'h3D, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h25,
                            8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5B, 8'h5D});
    c.is_idmid = c.is_alpha || c.is_digit || (b == CH_UNDERSCORE) || (b == CH_QUOTE);
    c.is_nl    = (b == CH_NEWLINE);
    return c;
  endfunction

  assign full        = (cnt_q == 2'd2);
  assign accept      = push && !full;
  assign cls_valid_o = (cnt_q != 2'd0);
  assign take        = cls_take_i && cls_valid_o;
  assign cls_o       = fifo_q[rptr_q];

  always_comb begin
    wptr_d = accept ? !wptr_q : wptr_q;
    rptr_d = take ? !rptr_q : rptr_q;
    cnt_d  = cnt_q;
    if (accept && !take) begin
      cnt_d = cnt_q + 2'd1;
    end else if (take && !accept) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fifo_q[wptr_q] <= classify(source_byte_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

FILE: sv/stl_back.sv
module stl_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  stl_pkg::byte_class_t cls_i,
  input  logic                 cls_valid_i,
  output logic                 cls_take_o,
  input  logic                 room_i,
  output stl_pkg::rq_push_t    push_o,
  output stl_pkg::result_t     res0_o,
  output stl_pkg::result_t     res1_o
);
  import stl_pkg::*;

  mode_e       mode_q, mode_d;
  pos_t        cur_row_q, cur_row_d;
  pos_t        cur_col_q, cur_col_d;
  pos_t        tok_row_q, tok_row_d;
  pos_t        tok_col_q, tok_col_d;
  logic [63:0] accum_q, accum_d;
  logic [1:0]  dots_q, dots_d;
  logic        ovf_q, ovf_d;

  pos_t        adv_row, adv_col;
  logic [67:0] acc_ext, acc_next;
  logic        consume;
  logic        close_vld, new_vld;
  result_t     close_res, new_res;

  function automatic result_t mk_res(kind_e k, logic [7:0] p, logic [63:0] v,
                                     pos_t sr, pos_t sc, pos_t er, pos_t ec, err_e e);
    result_t r;
    r.kind      = k;
    r.punct     = p;
    r.value     = v;
    r.first_row = pos_field(sr);
    r.first_col = pos_field(sc);
    r.end_row   = pos_field(er);
    r.end_col   = pos_field(ec);
    r.err       = e;
    r.last      = 1'b0;
    return r;
  endfunction

  assign cls_take_o = cls_valid_i && room_i;

  // Position after the current byte, saturating.
  always_comb begin
    adv_row = cur_row_q;
    adv_col = cur_col_q;
    if (cls_i.is_nl) begin
      if (cur_row_q != POS_MAX) begin
        adv_row = cur_row_q + POS_ONE;
      end
      adv_col = POS_ONE;
    end else if (cur_col_q != POS_MAX) begin
      adv_col = cur_col_q + POS_ONE;
    end
  end

  // accum * 10 + digit, with four guard bits to catch overflow.
  assign acc_ext  = {4'b0000, accum_q};
  assign acc_next = (acc_ext << 3) + (acc_ext << 1) + 68'(cls_i.digit);

  always_comb begin
    consume = ((mode_q == MODE_ID) && cls_i.is_idmid) ||
              ((mode_q == MODE_NUM) && (cls_i.is_digit || cls_i.is_dot)) ||
              ((mode_q == MODE_DOT) && cls_i.is_digit);

    // Token that the current byte closes, ending at the position of that byte.
    close_vld = (mode_q != MODE_IDLE);
    close_res = mk_res(KIND_IDENT, 8'h00, 64'd0, tok_row_q, tok_col_q,
                       cur_row_q, cur_col_q, ERR_NONE);
    case (mode_q)
      MODE_NUM: begin
        if (dots_q == 2'd0) begin
          if (ovf_q) begin
            close_res.kind = KIND_ERROR;
            close_res.err  = ERR_INT_RANGE;
          end else begin
            close_res.kind  = KIND_INT;
            close_res.value = accum_q;
          end
        end else if (dots_q == 2'd1) begin
          close_res.kind = KIND_FLOAT;
        end else begin
          close_res.kind = KIND_ERROR;
          close_res.err  = ERR_BAD_FLOAT;
        end
      end
      MODE_DOT: begin
        close_res.kind  = KIND_PUNCT;
        close_res.punct = CH_DOT;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    mode_d    = mode_q;
    cur_row_d = cur_row_q;
    cur_col_d = cur_col_q;
    tok_row_d = tok_row_q;
    tok_col_d = tok_col_q;
    accum_d   = accum_q;
    dots_d    = dots_q;
    ovf_d     = ovf_q;
    new_vld   = 1'b0;
    new_res   = mk_res(KIND_END, 8'h00, 64'd0, cur_row_q, cur_col_q,
                       cur_row_q, cur_col_q, ERR_NONE);
    push_o    = '0;

    if (cls_take_o) begin
      if (consume) begin
        cur_row_d = adv_row;
        cur_col_d = adv_col;
        if (mode_q == MODE_DOT) begin
          mode_d = MODE_NUM;
          dots_d = 2'd1;
        end else if (mode_q == MODE_NUM) begin
          if (cls_i.is_dot) begin
            if (dots_q != 2'd2) begin
              dots_d = dots_q + 2'd1;
            end
          end else if (dots_q == 2'd0) begin
            if (acc_next[67:64] != 4'd0) begin
              ovf_d = 1'b1;
            end
            accum_d = acc_next[63:0];
          end
        end
      end else begin
        mode_d = MODE_IDLE;
        if (cls_i.is_zero) begin
          new_vld   = 1'b1;
          cur_row_d = POS_ONE;
          cur_col_d = POS_ONE;
          tok_row_d = POS_ONE;
          tok_col_d = POS_ONE;
        end else if (cls_i.is_space) begin
          cur_row_d = adv_row;
          cur_col_d = adv_col;
        end else if (cls_i.is_alpha || cls_i.is_digit || cls_i.is_dot) begin
          tok_row_d = cur_row_q;
          tok_col_d = cur_col_q;
          dots_d    = 2'd0;
          ovf_d     = 1'b0;
          accum_d   = cls_i.is_digit ? 64'(cls_i.digit) : 64'd0;
          mode_d    = cls_i.is_alpha ? MODE_ID : (cls_i.is_digit ? MODE_NUM : MODE_DOT);
          cur_row_d = adv_row;
          cur_col_d = adv_col;
        end else begin
          new_vld   = 1'b1;
          cur_row_d = adv_row;
          cur_col_d = adv_col;
          if (cls_i.is_punct) begin
            new_res = mk_res(KIND_PUNCT, cls_i.ch, 64'd0, cur_row_q, cur_col_q,
                             adv_row, adv_col, ERR_NONE);
          end else begin
            new_res = mk_res(KIND_ERROR, 8'h00, 64'd0, cur_row_q, cur_col_q,
                             adv_row, adv_col, ERR_UNEXPECTED);
          end
        end
        push_o.push0 = close_vld || new_vld;
        push_o.push1 = close_vld && new_vld;
      end
    end

    res0_o      = close_vld ? close_res : new_res;
    res0_o.last = !push_o.push1;
    res1_o      = new_res;
    res1_o.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      cur_row_q <= POS_ONE;
      cur_col_q <= POS_ONE;
      tok_row_q <= POS_ONE;
      tok_col_q <= POS_ONE;
      accum_q   <= 64'd0;
      dots_q    <= 2'd0;
      ovf_q     <= 1'b0;
    end else begin
      mode_q    <= mode_d;
      cur_row_q <= cur_row_d;
      cur_col_q <= cur_col_d;
      tok_row_q <= tok_row_d;
      tok_col_q <= tok_col_d;
      accum_q   <= accum_d;
      dots_q    <= dots_d;
      ovf_q     <= ovf_d;
    end
  end

endmodule

FILE: sv/stl_resq.sv
module stl_resq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  stl_pkg::rq_push_t push_i,
  input  stl_pkg::result_t  res0_i,
  input  stl_pkg::result_t  res1_i,
  input  logic              pop,
  output logic              empty,
  output logic              room_o,
  output stl_pkg::result_t  head_o
);
  import stl_pkg::*;

  result_t    mem_q [4];
  logic [1:0] wptr_q, wptr_d;
  logic [1:0] rptr_q, rptr_d;
  logic [2:0] cnt_q, cnt_d;
  logic       pop_ok;

  assign empty  = (cnt_q == 3'd0);
  assign room_o = (cnt_q <= 3'd2);
  assign pop_ok = pop && !empty;
  assign head_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q + 2'(push_i.push0) + 2'(push_i.push1);
    rptr_d = rptr_q + 2'(pop_ok);
    cnt_d  = cnt_q + 3'(push_i.push0) + 3'(push_i.push1) - 3'(pop_ok);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      mem_q[wptr_q] <= res0_i;
    end
    if (push_i.push1) begin
      mem_q[wptr_q + 2'd1] <= res1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 2'd0;
      rptr_q <= 2'd0;
      cnt_q  <= 3'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

FILE: sv/stl_checker.sv
module stl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [2:0]  token_kind_o,
  input logic [7:0]  punct_char_o,
  input logic [63:0] int_value_o,
  input logic [15:0] first_row_o,
  input logic [15:0] first_col_o,
  input logic [15:0] end_row_o,
  input logic [15:0] end_col_o
);
  import stl_pkg::*;

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result queue not empty during reset");

  // A waiting result that is not popped stays put.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(token_kind_o) && $stable(first_col_o))
    else $error("stalled result changed");

  // Only integer tokens carry a value; punctuation always names its character.
  a_value_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && (token_kind_o != KIND_INT) |-> (int_value_o == 64'd0) &&
    ((token_kind_o == KIND_PUNCT) == (punct_char_o != 8'h00)))
    else $error("value or punctuation field inconsistent with token kind");

  // An end token starts and ends at the same place.
  a_end_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && (token_kind_o == KIND_END) |->
    (first_row_o == end_row_o) && (first_col_o == end_col_o))
    else $error("end token with differing start and end position");

endmodule

bind source_token_lexer_core stl_checker u_stl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .empty        (empty),
  .pop          (pop),
  .token_kind_o (token_kind_o),
  .punct_char_o (punct_char_o),
  .int_value_o  (int_value_o),
  .first_row_o  (first_row_o),
  .first_col_o  (first_col_o),
  .end_row_o    (end_row_o),
  .end_col_o    (end_col_o)
);
